>>> rtl/pf_pkg.sv
// Shared types and constants for the prime factorizer.
`default_nettype none

package pf_pkg;

	localparam int FACTOR_BITS = 31;
	localparam int EXP_BITS    = 5;
	localparam logic [EXP_BITS-1:0] EXP_MAX = '1;
	localparam int OUT_W       = 40;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_CHECK,
		ST_PUSH,
		ST_TAIL,
		ST_LAST
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic start_div;
		logic take_quot;
		logic push_factor;
		logic push_tail;
		logic advance_d;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic in_small;
		logic div_done;
		logic e_nz;
		logic d_gt_q;
		logic rem_zero;
		logic n_gt1;
		logic out_free;
		logic pend_valid;
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/prime_factorizer.sv
// Top level of the prime factorizer.
`default_nettype none

// Takes one positive integer per input transfer and returns its prime
// factorization as a run of output transfers, primes in ascending order,
// each with its multiplicity; tlast marks the final factor. An input of 1
// gives factor 1 exponent 1; an input of 0 gives factor 0 exponent 0 as an
// error marker. One item is worked at a time: s_tready is high only while
// the block is idle. Each trial divisor (2, then odd numbers while d*d
// does not exceed the cofactor) costs one pass of the shared bit-serial
// divider, setup and decision step included; each further division by a
// prime found costs another pass. The worst case at 31 bits is a large
// prime, roughly 23170 divisors. Results leave through a one-deep output
// register plus one held pending factor, so the search keeps running while
// a result waits.
module prime_factorizer #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [VALUE_BITS-1:0] value, upper bits zero
	input  wire logic [((VALUE_BITS+7)/8)*8-1:0]    s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [30:0] factor, [35:31] exponent, [39:36] zero
	output logic [pf_pkg::OUT_W-1:0]                m_tdata,
	output logic                                    m_tlast
);

	localparam int PAD_W = pf_pkg::OUT_W - pf_pkg::FACTOR_BITS - pf_pkg::EXP_BITS;

	pf_pkg::cmd_t  cmd;
	pf_pkg::stat_t stat;

	logic [pf_pkg::FACTOR_BITS-1:0] out_factor;
	logic [pf_pkg::EXP_BITS-1:0]    out_exp;

	pf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	pf_datapath #(.W(VALUE_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_value   (s_tdata[VALUE_BITS-1:0]),
		.out_factor (out_factor),
		.out_exp    (out_exp),
		.out_last   (m_tlast),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready)
	);

	assign s_tready = cmd.in_ready;
	assign m_tdata  = {{PAD_W{1'b0}}, out_exp, out_factor};

`ifndef ASSERT_OFF
	// one item at a time: ready drops right after an accepted transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// nothing may stay pending once the block is idle again
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.pend_valid)
		else $error("pending factor left over at idle");

	// a zero exponent only ever pairs with the zero-input marker
	a_exp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[35:31] != '0) || (m_tdata[30:0] == '0))
		else $error("zero exponent on a real factor");
`endif

endmodule

`default_nettype wire

>>> rtl/pf_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module pf_div #(
	parameter int W = 31
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic      [W-1:0] quot,
	output logic      [W-1:0] rem,
	output logic              done
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign quot = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

>>> rtl/pf_datapath.sv
// Datapath: cofactor, trial divisor, exponent, pending factor and output register.
`default_nettype none

module pf_datapath #(
	parameter int W = 31
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pf_pkg::cmd_t                     cmd,
	output pf_pkg::stat_t                         stat,
	input  wire logic [W-1:0]                     in_value,
	output logic      [pf_pkg::FACTOR_BITS-1:0]   out_factor,
	output logic      [pf_pkg::EXP_BITS-1:0]      out_exp,
	output logic                                  out_last,
	output logic                                  out_valid,
	input  wire logic                             out_ready
);

	logic [W-1:0] n_q;
	logic [W-1:0] d_q;
	logic [pf_pkg::EXP_BITS-1:0] e_q;
	logic [W-1:0] pf_q;
	logic [pf_pkg::EXP_BITS-1:0] pe_q;
	logic         pv_q;
	logic [pf_pkg::FACTOR_BITS-1:0] of_q;
	logic [pf_pkg::EXP_BITS-1:0]    oe_q;
	logic         ol_q;
	logic         ov_q;

	logic [W-1:0] quot;
	logic [W-1:0] rem;
	logic         div_done;
	logic         push;

	pf_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (n_q),
		.divisor  (d_q),
		.quot     (quot),
		.rem      (rem),
		.done     (div_done)
	);

	assign push = cmd.push_factor | cmd.push_tail;

	always_comb begin
		stat.in_small   = (in_value <= W'(1));
		stat.div_done   = div_done;
		stat.e_nz       = (e_q != '0);
		stat.d_gt_q     = (d_q > quot);
		stat.rem_zero   = (rem == '0);
		stat.n_gt1      = (n_q > W'(1));
		stat.out_free   = !ov_q || out_ready;
		stat.pend_valid = pv_q;
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cmd.load)
				pv_q <= stat.in_small;
			else if (push)
				pv_q <= 1'b1;
			else if (cmd.emit_last)
				pv_q <= 1'b0;

			if ((push && pv_q) || cmd.emit_last)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= in_value;
			d_q  <= W'(2);
			e_q  <= '0;
			pf_q <= in_value;
			pe_q <= pf_pkg::EXP_BITS'(in_value[0]);
		end else begin
			if (cmd.take_quot) begin
				n_q <= quot;
				if (e_q != pf_pkg::EXP_MAX)
					e_q <= e_q + 1'b1;
			end
			if (cmd.advance_d)
				d_q <= (d_q == W'(2)) ? W'(3) : d_q + W'(2);
			if (push) begin
				if (pv_q) begin
					of_q <= pf_pkg::FACTOR_BITS'(pf_q);
					oe_q <= pe_q;
					ol_q <= 1'b0;
				end
				pf_q <= cmd.push_tail ? n_q : d_q;
				pe_q <= cmd.push_tail ? pf_pkg::EXP_BITS'(1) : e_q;
				e_q  <= '0;
			end
			if (cmd.emit_last) begin
				of_q <= pf_pkg::FACTOR_BITS'(pf_q);
				oe_q <= pe_q;
				ol_q <= 1'b1;
			end
		end
	end

	assign out_factor = of_q;
	assign out_exp    = oe_q;
	assign out_last   = ol_q;
	assign out_valid  = ov_q;

endmodule

`default_nettype wire

>>> rtl/pf_ctrl.sv
// Controller state machine for the trial-division loop.
`default_nettype none

module pf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire pf_pkg::stat_t stat,
	output pf_pkg::cmd_t       cmd
);

	pf_pkg::state_t state_q;
	pf_pkg::state_t state_nx;
	logic           can_push;

	assign can_push = stat.out_free || !stat.pend_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pf_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pf_pkg::ST_IDLE: begin
				if (in_valid)
					state_nx = stat.in_small ? pf_pkg::ST_LAST : pf_pkg::ST_START;
			end
			pf_pkg::ST_START: state_nx = pf_pkg::ST_DIV;
			pf_pkg::ST_DIV: begin
				if (stat.div_done)
					state_nx = pf_pkg::ST_CHECK;
			end
			pf_pkg::ST_CHECK: begin
				if (!stat.e_nz && stat.d_gt_q)
					state_nx = pf_pkg::ST_TAIL;
				else if (stat.rem_zero)
					state_nx = pf_pkg::ST_START;
				else if (stat.e_nz)
					state_nx = pf_pkg::ST_PUSH;
				else
					state_nx = pf_pkg::ST_START;
			end
			pf_pkg::ST_PUSH: begin
				if (can_push)
					state_nx = pf_pkg::ST_START;
			end
			pf_pkg::ST_TAIL: begin
				if (!stat.n_gt1 || can_push)
					state_nx = pf_pkg::ST_LAST;
			end
			pf_pkg::ST_LAST: begin
				if (stat.out_free)
					state_nx = pf_pkg::ST_IDLE;
			end
			default: state_nx = pf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			pf_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = in_valid;
			end
			pf_pkg::ST_START: cmd.start_div = 1'b1;
			pf_pkg::ST_CHECK: begin
				if (!(!stat.e_nz && stat.d_gt_q)) begin
					if (stat.rem_zero)
						cmd.take_quot = 1'b1;
					else if (!stat.e_nz)
						cmd.advance_d = 1'b1;
				end
			end
			pf_pkg::ST_PUSH: begin
				cmd.push_factor = can_push;
				cmd.advance_d   = can_push;
			end
			pf_pkg::ST_TAIL: cmd.push_tail = stat.n_gt1 && can_push;
			pf_pkg::ST_LAST: cmd.emit_last = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> sim/prime_factorizer_tb.sv
// Testbench for prime_factorizer: directed and random values checked against a trial-division predictor.
`timescale 1ns / 1ps

module prime_factorizer_tb;

	localparam int VALUE_BITS = 31;
	localparam int IN_W = ((VALUE_BITS + 7) / 8) * 8;
	localparam longint unsigned VALUE_LIMIT = 64'd1 << VALUE_BITS;
	// Slowest correct run: one full-range prime plus ~120 small items, with
	// gaps and a slow receiver. Taken several times over.
	localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
	localparam int LONG_STALL = 4000;
	// One divider pass, setup and decision step included.
	localparam int PASS_CYCLES = VALUE_BITS + 3;
	localparam int N_SMALL_PRIMES = 15;

	typedef struct {
		bit [pf_pkg::FACTOR_BITS-1:0] factor;
		bit [pf_pkg::EXP_BITS-1:0]    exponent;
		bit                           last;
	} factor_entry_t;

	localparam int SMALL_PRIMES [N_SMALL_PRIMES] =
		'{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_W-1:0]          s_tdata = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [pf_pkg::OUT_W-1:0] m_tdata;
	logic                     m_tlast;

	// Factorization results still owed by the block, oldest first.
	factor_entry_t expected_factors[$];

	int              error_count = 0;
	longint unsigned cycle_count = 0;
	int              burst_left = 0;

	// Long receiver hold-off: the test bumps stall_ask, the receiver notices.
	int stall_ask = 0;
	int stall_seen = 0;
	int hold_cycles = 0;
	int mode_left = 0;
	int ready_mode = 0;

	prime_factorizer #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL prime_factorizer");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		if (error_count < 40)
			$display("mismatch %s: expected %0d got %0d (cycle %0d)", what, want, got,
				cycle_count);
		error_count++;
	endtask

	// Trial division: 2, then odd divisors while d*d <= cofactor; a leftover
	// cofactor above 1 is a large prime. 0 gives the error marker, 1 gives 1^1.
	function automatic void predict_factors(input bit [VALUE_BITS-1:0] value);
		longint unsigned n;
		longint unsigned d;
		int unsigned     e;
		n = value;
		if (n == 0) begin
			expected_factors.push_back('{'0, '0, 1'b1});
			return;
		end
		if (n == 1) begin
			expected_factors.push_back('{1, 1, 1'b1});
			return;
		end
		d = 2;
		while (d <= n / d) begin
			if (n % d == 0) begin
				e = 0;
				while (n % d == 0) begin
					n = n / d;
					e++;
				end
				expected_factors.push_back('{d[pf_pkg::FACTOR_BITS-1:0],
					e[pf_pkg::EXP_BITS-1:0], 1'b0});
			end
			d = (d == 2) ? 3 : d + 2;
		end
		if (n > 1)
			expected_factors.push_back('{n[pf_pkg::FACTOR_BITS-1:0], 1, 1'b0});
		expected_factors[expected_factors.size() - 1].last = 1'b1;
	endfunction

	// Product of random small primes times a small random cofactor: large
	// values with many factors that still finish after a few dozen divisors.
	function automatic bit [VALUE_BITS-1:0] smooth_value();
		longint unsigned n;
		longint unsigned p;
		longint unsigned r;
		n = 1;
		repeat ($urandom_range(1, 14)) begin
			p = SMALL_PRIMES[$urandom_range(0, N_SMALL_PRIMES - 1)];
			if (n * p < VALUE_LIMIT)
				n = n * p;
		end
		r = $urandom_range(1, 4095);
		if (n * r < VALUE_LIMIT)
			n = n * r;
		return n[VALUE_BITS-1:0];
	endfunction

	// One input transfer. The sender runs in bursts; a gap may open before an
	// item. tvalid stays high between items of a burst.
	task automatic send_value(input bit [VALUE_BITS-1:0] value);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0)
				gap = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 1500) :
					$urandom_range(1, 40);
		end
		burst_left--;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - VALUE_BITS){1'b0}}, value};
		do @(posedge clk); while (!s_tready);
		predict_factors(value);
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_factors.size() != 0) @(posedge clk);
		repeat (2 * PASS_CYCLES) @(posedge clk);
	endtask

	// Receiver: a long hold-off on request, otherwise a changing pattern of
	// always ready, coin-flip and mostly stalled stretches.
	always @(posedge clk) begin
		if (stall_ask != stall_seen) begin
			stall_seen <= stall_ask;
			hold_cycles <= LONG_STALL;
			m_tready <= 1'b0;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode_left <= $urandom_range(20, 400);
				ready_mode <= $urandom_range(0, 2);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// Compare each result transfer with the oldest owed result.
	always @(posedge clk) begin : result_check
		factor_entry_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_factors.size() == 0) begin
				report_mismatch("result with nothing owed", 0, m_tdata);
			end else begin
				want = expected_factors.pop_front();
				if (m_tdata[pf_pkg::FACTOR_BITS-1:0] != want.factor)
					report_mismatch("factor", want.factor,
						m_tdata[pf_pkg::FACTOR_BITS-1:0]);
				if (m_tdata[pf_pkg::FACTOR_BITS +: pf_pkg::EXP_BITS] != want.exponent)
					report_mismatch("exponent", want.exponent,
						m_tdata[pf_pkg::FACTOR_BITS +: pf_pkg::EXP_BITS]);
				if (m_tlast != want.last)
					report_mismatch("tlast", want.last, m_tlast);
				if (m_tdata[pf_pkg::OUT_W-1:pf_pkg::FACTOR_BITS+pf_pkg::EXP_BITS] != '0)
					report_mismatch("pad bits", 0,
						m_tdata[pf_pkg::OUT_W-1:pf_pkg::FACTOR_BITS+pf_pkg::EXP_BITS]);
			end
		end
	end

	task automatic test_directed_values();
		send_value(0);            // error marker
		send_value(1);            // 1^1
		send_value(2);
		send_value(3);
		send_value(4);            // d*d equal to the value
		send_value(9);
		send_value(25);
		send_value(49);
		send_value(65521);        // prime above the square-root bound
		send_value(131042);       // 2 * 65521: large prime left as cofactor
		send_value(31'h4000_0000); // 2^30, top exponent
		send_value(1162261467);   // 3^19
		send_value(223092870);    // first nine primes, most results
		send_value(2147483646);   // all bits but bit 0
		send_value(2147483647);   // full-range prime, slowest item
		drain_results();
	endtask

	// Receiver holds off while the sender keeps offering many-factor values,
	// so the output register and pending factor fill and the input stalls.
	task automatic test_long_stall();
		stall_ask <= stall_ask + 1;
		send_value(223092870);
		send_value(2147483646);
		repeat (8) send_value(smooth_value());
		drain_results();
	endtask

	task automatic test_random_values();
		longint unsigned n;
		longint unsigned p;
		repeat (100) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: n = smooth_value();
				4, 5, 6: n = $urandom_range(2, 65535);
				7: begin
					// power of one small prime
					p = SMALL_PRIMES[$urandom_range(0, N_SMALL_PRIMES - 1)];
					n = p;
					while (n * p < VALUE_LIMIT && $urandom_range(0, 7) != 0)
						n = n * p;
				end
				8: n = $urandom_range(65536, 1 << 20);
				default: n = $urandom_range(0, 2);
			endcase
			send_value(n[VALUE_BITS-1:0]);
		end
		drain_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_values();
		test_long_stall();
		test_random_values();
		if (error_count == 0)
			$display("PASS prime_factorizer");
		else
			$display("FAIL prime_factorizer");
		$finish;
	end

endmodule
